@@ hdl/matrix3_inverse_unit_top_assert.svh @@
// assertion macros shared by the matrix inverse unit
`ifndef MATRIX3_INVERSE_UNIT_TOP_ASSERT_SVH
`define MATRIX3_INVERSE_UNIT_TOP_ASSERT_SVH
// same-cycle implication, checked out of reset
`define MI3_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define MI3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hdl/mi3_pkg.sv @@
// shared widths, types, tables and saturation for the matrix inverse unit
`default_nettype none
package mi3_pkg;
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;
    localparam int DIV_LAT   = QUO_BITS + 2;
    localparam int SAT_W     = 2 * WORD_BITS + 2;
    localparam int N_ELEM    = 9;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [SAT_W-1:0]     t_wide;

    typedef enum logic [1:0] {
        OP_TRANSPOSE = 2'd0,
        OP_COFACTOR  = 2'd1,
        OP_INVERSE   = 2'd2,
        OP_DET       = 2'd3
    } t_op;

    // payload that travels beside the divider lanes
    typedef struct packed {
        t_op   opcode;
        t_word det;
        logic  singular;
        logic [N_ELEM-1:0][WORD_BITS-1:0] alt;
    } t_side;

    // element indices a, b, c, d of each cofactor a*b - c*d, row-major
    localparam int COF_IDX [N_ELEM][4] = '{
        '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
        '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
        '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
    };

    // clamp a wide signed value into the word range
    function automatic t_word f_sat(input t_wide x);
        t_wide maxv;
        t_wide minv;
        maxv = t_wide'({1'b0, {(WORD_BITS-1){1'b1}}});
        minv = -maxv - t_wide'(1);
        if (x > maxv) begin
            f_sat = t_word'(maxv);
        end else if (x < minv) begin
            f_sat = t_word'(minv);
        end else begin
            f_sat = t_word'(x);
        end
    endfunction
endpackage
`default_nettype wire

@@ hdl/mi3_cof_lane.sv @@
// one cofactor lane: two floored products, difference, saturation
`default_nettype none
module mi3_cof_lane (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire mi3_pkg::t_word i_a,
    input  wire mi3_pkg::t_word i_b,
    input  wire mi3_pkg::t_word i_c,
    input  wire mi3_pkg::t_word i_d,
    output mi3_pkg::t_word     o_cof
);
    import mi3_pkg::*;

    logic signed [2*WORD_BITS-1:0] n_p1;
    logic signed [2*WORD_BITS-1:0] n_p2;
    logic signed [2*WORD_BITS-1:0] r_p1;
    logic signed [2*WORD_BITS-1:0] r_p2;
    t_wide                         n_diff;
    t_word                         r_cof;

    // full products, floored by the fraction shift
    assign n_p1 = i_a * i_b;
    assign n_p2 = i_c * i_d;
    assign n_diff = t_wide'(r_p1) - t_wide'(r_p2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1  <= n_p1 >>> FRAC_BITS;
            r_p2  <= n_p2 >>> FRAC_BITS;
            r_cof <= f_sat(n_diff);
        end
    end

    assign o_cof = r_cof;
endmodule
`default_nettype wire

@@ hdl/mi3_div_lane.sv @@
// one divider lane: restoring division, one quotient bit per stage
`default_nettype none
module mi3_div_lane (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire mi3_pkg::t_word i_num,
    input  wire mi3_pkg::t_word i_den,
    output mi3_pkg::t_word      o_quo
);
    import mi3_pkg::*;

    logic [WORD_BITS:0]     r_rem [QUO_BITS+1];
    logic [QUO_BITS-1:0]    r_dvd [QUO_BITS+1];
    logic [QUO_BITS-1:0]    r_q   [QUO_BITS+1];
    logic [WORD_BITS-1:0]   r_md  [QUO_BITS+1];
    logic                   r_neg [QUO_BITS+1];
    logic [WORD_BITS:0]     n_rem [QUO_BITS+1];
    logic [QUO_BITS-1:0]    n_q   [QUO_BITS+1];
    logic [WORD_BITS-1:0]   n_mn;
    logic [WORD_BITS-1:0]   n_md;
    logic signed [QUO_BITS:0] n_sq;
    t_word                  r_quo;

    // magnitudes of the operands
    assign n_mn = i_num[WORD_BITS-1] ? WORD_BITS'(-i_num) : WORD_BITS'(i_num);
    assign n_md = i_den[WORD_BITS-1] ? WORD_BITS'(-i_den) : WORD_BITS'(i_den);

    // one shift-compare-subtract step per stage
    always_comb begin
        n_rem[0] = '0;
        n_q[0]   = '0;
        for (int k = 1; k <= QUO_BITS; k++) begin
            logic [WORD_BITS:0] t;
            t = {r_rem[k-1][WORD_BITS-1:0], r_dvd[k-1][QUO_BITS-1]};
            if (t >= {1'b0, r_md[k-1]}) begin
                n_rem[k] = t - {1'b0, r_md[k-1]};
                n_q[k]   = {r_q[k-1][QUO_BITS-2:0], 1'b1};
            end else begin
                n_rem[k] = t;
                n_q[k]   = {r_q[k-1][QUO_BITS-2:0], 1'b0};
            end
        end
    end

    // sign and clamp of the final quotient
    assign n_sq = r_neg[QUO_BITS] ? -$signed({1'b0, r_q[QUO_BITS]})
                                  : $signed({1'b0, r_q[QUO_BITS]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_dvd[0] <= {n_mn, {FRAC_BITS{1'b0}}};
            r_md[0]  <= n_md;
            r_neg[0] <= i_num[WORD_BITS-1] ^ i_den[WORD_BITS-1];
            for (int k = 1; k <= QUO_BITS; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_dvd[k] <= r_dvd[k-1] << 1;
                r_md[k]  <= r_md[k-1];
                r_neg[k] <= r_neg[k-1];
            end
            r_quo <= f_sat(t_wide'(n_sq));
        end
    end

    assign o_quo = r_quo;
endmodule
`default_nettype wire

@@ hdl/matrix3_inverse_unit_top.sv @@
// top level: 3x3 transpose, cofactor, inverse and determinant pipeline
`default_nettype none
// One 3x3 Q16.16 matrix beat is taken every cycle while the output side
// keeps up. Nine cofactor lanes form the minors in registered product and
// difference steps, a merge stage forms the determinant from registered
// row products, and nine pipelined divider lanes, one quotient bit per
// stage over 48 stages plus entry and exit registers, scale the adjugate
// by the determinant. The whole pipe advances whenever the output
// register is empty or being taken, so a stalled output holds every stage.
module matrix3_inverse_unit_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [1:0]     i_opcode,
    input  wire mi3_pkg::t_word i_e00,
    input  wire mi3_pkg::t_word i_e01,
    input  wire mi3_pkg::t_word i_e02,
    input  wire mi3_pkg::t_word i_e10,
    input  wire mi3_pkg::t_word i_e11,
    input  wire mi3_pkg::t_word i_e12,
    input  wire mi3_pkg::t_word i_e20,
    input  wire mi3_pkg::t_word i_e21,
    input  wire mi3_pkg::t_word i_e22,
    output logic                o_valid,
    input  wire logic           i_ready,
    output mi3_pkg::t_word      o_r00,
    output mi3_pkg::t_word      o_r01,
    output mi3_pkg::t_word      o_r02,
    output mi3_pkg::t_word      o_r10,
    output mi3_pkg::t_word      o_r11,
    output mi3_pkg::t_word      o_r12,
    output mi3_pkg::t_word      o_r20,
    output mi3_pkg::t_word      o_r21,
    output mi3_pkg::t_word      o_r22,
    output mi3_pkg::t_word      o_det_value,
    output logic                o_singular
);
    import mi3_pkg::*;

    localparam int N_STG = 4 + DIV_LAT;

    logic                          w_adv;
    t_word                         w_e   [N_ELEM];
    t_word                         w_cof [N_ELEM];
    t_word                         w_quo [N_ELEM];
    t_word                         w_res [N_ELEM];
    logic [N_STG-1:0]              r_vld;
    t_word                         r_e1 [N_ELEM];
    t_word                         r_e2 [N_ELEM];
    t_word                         r_e3 [N_ELEM];
    t_word                         r_c3 [N_ELEM];
    t_word                         r_c4 [N_ELEM];
    t_op                           r_op1, r_op2, r_op3, r_op4;
    logic signed [2*WORD_BITS-1:0] n_dp [3];
    logic signed [2*WORD_BITS-1:0] r_dp [3];
    t_wide                         n_dsum;
    t_word                         r_det;
    logic [N_ELEM-1:0][WORD_BITS-1:0] r_alt;
    t_side                         r_side [DIV_LAT];
    t_side                         w_last;

    // pipe moves when the output register is free
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[N_STG-1];

    assign w_e[0] = i_e00;
    assign w_e[1] = i_e01;
    assign w_e[2] = i_e02;
    assign w_e[3] = i_e10;
    assign w_e[4] = i_e11;
    assign w_e[5] = i_e12;
    assign w_e[6] = i_e20;
    assign w_e[7] = i_e21;
    assign w_e[8] = i_e22;

    // valid tracking through all stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[N_STG-2:0], i_valid};
        end
    end

    // cofactor lanes
    for (genvar k = 0; k < N_ELEM; k++) begin : g_cof
        mi3_cof_lane u_cof (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (w_e[COF_IDX[k][0]]),
            .i_b   (w_e[COF_IDX[k][1]]),
            .i_c   (w_e[COF_IDX[k][2]]),
            .i_d   (w_e[COF_IDX[k][3]]),
            .o_cof (w_cof[k])
        );
    end

    // determinant products along the first row
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_dp[j] = r_e2[j] * w_cof[j];
        end
    end
    assign n_dsum = t_wide'(r_dp[0]) + t_wide'(r_dp[1]) + t_wide'(r_dp[2]);

    // element delay, determinant merge and non-inverse result
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e1  <= w_e;
            r_e2  <= r_e1;
            r_e3  <= r_e2;
            r_c3  <= w_cof;
            r_c4  <= r_c3;
            r_op1 <= t_op'(i_opcode);
            r_op2 <= r_op1;
            r_op3 <= r_op2;
            r_op4 <= r_op3;
            for (int j = 0; j < 3; j++) begin
                r_dp[j] <= n_dp[j] >>> FRAC_BITS;
            end
            r_det <= f_sat(n_dsum);
            for (int k = 0; k < N_ELEM; k++) begin
                unique case (r_op3)
                    OP_TRANSPOSE: r_alt[k] <= r_e3[(k % 3) * 3 + k / 3];
                    OP_COFACTOR:  r_alt[k] <= r_c3[k];
                    OP_INVERSE:   r_alt[k] <= '0;
                    OP_DET:       r_alt[k] <= '0;
                    default:      r_alt[k] <= '0;
                endcase
            end
        end
    end

    // divider lanes on the adjugate
    for (genvar k = 0; k < N_ELEM; k++) begin : g_div
        mi3_div_lane u_div (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_num (r_c4[(k % 3) * 3 + k / 3]),
            .i_den (r_det),
            .o_quo (w_quo[k])
        );
    end

    // side payload beside the dividers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= '{opcode: r_op4, det: r_det, singular: (r_det == '0), alt: r_alt};
            for (int s = 1; s < DIV_LAT; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // output select
    assign w_last = r_side[DIV_LAT-1];
    always_comb begin
        for (int k = 0; k < N_ELEM; k++) begin
            if (w_last.opcode == OP_INVERSE) begin
                w_res[k] = w_last.singular ? t_word'(0) : w_quo[k];
            end else begin
                w_res[k] = t_word'(w_last.alt[k]);
            end
        end
    end

    assign o_r00       = w_res[0];
    assign o_r01       = w_res[1];
    assign o_r02       = w_res[2];
    assign o_r10       = w_res[3];
    assign o_r11       = w_res[4];
    assign o_r12       = w_res[5];
    assign o_r20       = w_res[6];
    assign o_r21       = w_res[7];
    assign o_r22       = w_res[8];
    assign o_det_value = w_last.det;
    assign o_singular  = w_last.singular;

    `include "matrix3_inverse_unit_top_assert.svh"

    `MI3_ASSERT_NOW(a_sing_flag, o_valid, o_singular == (o_det_value == '0), "singular flag mismatch")
    `MI3_ASSERT_NOW(a_sing_zero, o_valid && o_singular && w_last.opcode == OP_INVERSE, o_r00 == '0 && o_r11 == '0 && o_r22 == '0 && o_r01 == '0 && o_r12 == '0, "singular inverse not zero")
    `MI3_ASSERT_NOW(a_det_only, o_valid && w_last.opcode == OP_DET, o_r00 == '0 && o_r10 == '0 && o_r20 == '0 && o_r02 == '0, "determinant-only beat has matrix data")
    `MI3_ASSERT_NEXT(a_accept, i_valid && o_ready, r_vld[0], "accepted beat not tracked")
endmodule
`default_nettype wire

@@ bench/matrix3_inverse_unit_checker.sv @@
// checker for the matrix inverse unit: watches both channels, predicts and compares beats
module matrix3_inverse_unit_checker
    import mi3_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic [1:0]            i_opcode,
    input  wire logic [8:0][31:0]      i_elem,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic [8:0][31:0]      i_res,
    input  wire logic [31:0]           i_det,
    input  wire logic                  i_singular,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_big;

    typedef struct {
        t_word res [9];
        t_word det;
        logic  singular;
    } t_matrix_result;

    t_matrix_result matrix_results_due [$];

    // clamp to the signed word range
    function automatic t_word clamp_word(input t_big x);
        t_big hi;
        t_big lo;
        hi = t_big'(64'sh7FFF_FFFF);
        lo = -hi - t_big'(1);
        if (x > hi) begin
            return t_word'(hi);
        end else if (x < lo) begin
            return t_word'(lo);
        end
        return t_word'(x);
    endfunction

    // q product floored toward minus infinity
    function automatic t_big qprod(input t_word a, input t_word b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return t_big'(p) >>> FRAC_BITS;
    endfunction

    function automatic t_matrix_result matrix_op(input t_op op, input logic [8:0][31:0] m);
        t_word e [3][3];
        t_word cof [3][3];
        t_big acc;
        t_big num;
        t_matrix_result r;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                e[i][j] = t_word'(m[i*3+j]);
            end
        end
        // cyclic index form gives the cofactor sign for free
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                cof[i][j] = clamp_word(qprod(e[(i+1)%3][(j+1)%3], e[(i+2)%3][(j+2)%3])
                                     - qprod(e[(i+1)%3][(j+2)%3], e[(i+2)%3][(j+1)%3]));
            end
        end
        acc = qprod(e[0][0], cof[0][0]) + qprod(e[0][1], cof[0][1])
            + qprod(e[0][2], cof[0][2]);
        r.det = clamp_word(acc);
        r.singular = (r.det == 0);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                case (op)
                    OP_TRANSPOSE: r.res[i*3+j] = e[j][i];
                    OP_COFACTOR:  r.res[i*3+j] = cof[i][j];
                    OP_INVERSE: begin
                        if (r.singular) begin
                            r.res[i*3+j] = '0;
                        end else begin
                            num = t_big'(cof[j][i]) <<< FRAC_BITS;
                            r.res[i*3+j] = clamp_word(num / t_big'(r.det));
                        end
                    end
                    default:      r.res[i*3+j] = '0;
                endcase
            end
        end
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    // input beat: predict; output beat: compare with oldest prediction
    always @(posedge i_clk) begin
        t_matrix_result want;
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (matrix_results_due.size() == 0) begin
                $display("%0t: unexpected result beat det=%h", $time, i_det);
                o_fail_count++;
            end else begin
                want = matrix_results_due.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (i_res[k] !== want.res[k]) begin
                        $display("%0t: r%0d%0d expected %h actual %h", $time,
                                 k / 3, k % 3, want.res[k], i_res[k]);
                        o_fail_count++;
                    end
                end
                if (i_det !== want.det) begin
                    $display("%0t: det expected %h actual %h", $time, want.det, i_det);
                    o_fail_count++;
                end
                if (i_singular !== want.singular) begin
                    $display("%0t: singular expected %b actual %b", $time,
                             want.singular, i_singular);
                    o_fail_count++;
                end
            end
        end
        if (i_rst_n && i_in_valid && i_in_ready) begin
            matrix_results_due.push_back(matrix_op(t_op'(i_opcode), i_elem));
        end
        o_pending = matrix_results_due.size();
    end
endmodule

@@ bench/testbench.sv @@
// top of the matrix inverse unit bench: stimulus, idling and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mi3_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        opcode;
    logic [8:0][31:0]  elem;
    logic              out_valid;
    logic              out_ready;
    logic [8:0][31:0]  res;
    logic [31:0]       det;
    logic              singular;
    int                fail_count;
    int                pending;
    int                send_idle;
    int                recv_idle;

    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN = 32'h8000_0000;

    matrix3_inverse_unit_top u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_opcode(opcode),
        .i_e00(elem[0]), .i_e01(elem[1]), .i_e02(elem[2]),
        .i_e10(elem[3]), .i_e11(elem[4]), .i_e12(elem[5]),
        .i_e20(elem[6]), .i_e21(elem[7]), .i_e22(elem[8]),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_r00(res[0]), .o_r01(res[1]), .o_r02(res[2]),
        .o_r10(res[3]), .o_r11(res[4]), .o_r12(res[5]),
        .o_r20(res[6]), .o_r21(res[7]), .o_r22(res[8]),
        .o_det_value(det), .o_singular(singular)
    );

    matrix3_inverse_unit_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_opcode(opcode), .i_elem(elem), .i_out_valid(out_valid),
        .i_out_ready(out_ready), .i_res(res), .i_det(det), .i_singular(singular),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // receiver stalls at random
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // drive one matrix beat and hold it until taken
    task automatic send_matrix(input t_op op, input logic [8:0][31:0] m);
        while ($urandom_range(99) < send_idle) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        opcode = op;
        elem = m;
        in_valid = 1'b1;
        forever begin
            @(posedge clk);
            if (in_ready) break;
        end
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_elem(input int shape);
        case (shape)
            0: return $urandom();
            // up to ten units either side of zero, fractional bits random
            1: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
            // tiny values that drive the determinant toward zero
            2: return 32'($signed($urandom_range(0, 1024)) - 512);
            default: begin
                case ($urandom_range(3))
                    0: return W_MAX;
                    1: return W_MIN;
                    2: return '0;
                    default: return Q_ONE;
                endcase
            end
        endcase
    endfunction

    task automatic random_phase(input int n);
        logic [8:0][31:0] m;
        int shape;
        for (int k = 0; k < n; k++) begin
            shape = $urandom_range(9);
            shape = (shape < 3) ? 0 : (shape < 7) ? 1 : (shape < 8) ? 2 : 3;
            for (int j = 0; j < 9; j++) m[j] = rand_elem(shape);
            // copy one row onto another now and then to force a singular matrix
            if ($urandom_range(9) == 0) begin
                for (int j = 0; j < 3; j++) m[6+j] = m[j];
            end
            send_matrix(t_op'($urandom_range(3)), m);
        end
    endtask

    initial begin
        logic [8:0][31:0] m;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        opcode = '0;
        elem = '0;
        send_idle = 0;
        recv_idle = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // identity through every operation
        m = '{default: '0};
        m[0] = Q_ONE; m[4] = Q_ONE; m[8] = Q_ONE;
        for (int op = 0; op < 4; op++) send_matrix(t_op'(op), m);
        // distinct entries so the transpose and cofactor layout shows
        for (int j = 0; j < 9; j++) m[j] = (j + 1) * Q_ONE + j * 32'h1111;
        m[8] = 32'hFFF3_8000;
        for (int op = 0; op < 4; op++) send_matrix(t_op'(op), m);
        // all zero, all max, all min: singular and saturating cases
        send_matrix(OP_INVERSE, '0);
        send_matrix(OP_COFACTOR, {9{W_MAX}});
        send_matrix(OP_INVERSE, {9{W_MAX}});
        send_matrix(OP_COFACTOR, {9{W_MIN}});
        send_matrix(OP_DET, {9{W_MIN}});
        // diagonal max and min: huge determinant, saturating inverse
        m = '{default: '0};
        m[0] = W_MAX; m[4] = W_MIN; m[8] = W_MAX;
        send_matrix(OP_INVERSE, m);
        send_matrix(OP_DET, m);
        // tiny positive determinant that floors to zero
        m = '{default: '0};
        m[0] = 32'd1; m[4] = 32'd1; m[8] = 32'd1;
        send_matrix(OP_INVERSE, m);
        send_matrix(OP_TRANSPOSE, m);
        // smallest nonzero determinant: the first inverse entry saturates
        m = '{default: '0};
        m[0] = 32'd1; m[4] = Q_ONE; m[8] = Q_ONE;
        send_matrix(OP_INVERSE, m);
        // negative scaled identity
        m = '{default: '0};
        m[0] = 32'hFFFE_0000; m[4] = 32'hFFFE_0000; m[8] = 32'hFFFE_0000;
        send_matrix(OP_INVERSE, m);

        // random: sender light, receiver heavy; then reversed; then flat out
        send_idle = 29; recv_idle = 67;
        random_phase(380);
        send_idle = 67; recv_idle = 29;
        random_phase(380);
        send_idle = 0; recv_idle = 0;
        random_phase(390);
        in_valid = 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // hard limit on the run
    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
